// File: design/tccs_pkg.sv
// Shared constants and transaction types for the text console cursor and scroll block.
package tccs_pkg;

  localparam int COLUMNS_DEF = 64;
  localparam int ROWS_DEF    = 36;

  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_SPACE     = 8'd32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  char_code;
    logic [11:0] cell_address;
    logic        last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_char;
    logic [11:0] cursor_pos;
    logic        scrolled;
    logic        request_done;
  } out_item_t;

endpackage

// File: design/text_console_cursor_and_scroll.sv
// Top level of the text console: screen memory, cursor and a sequencer for reads and scrolling.
//
// Usage: one input channel (in_valid, in_stall, in_data) carries write or read transactions,
// one result channel (out_valid, out_stall, out_data) returns exactly one result per input
// transaction, in order. A write places one character at the cursor (backspace and newline
// are handled as control codes); a read returns one screen cell, or 0 beyond the screen.
// Sequence: a write that does not scroll goes to S_OUT after acceptance, a read first passes
// through S_READ for the registered memory read. A write that scrolls passes through S_COPY
// and S_FILL first: the single memory port pair moves one cell per cycle while rows shift up,
// then blanks the bottom row one cell per cycle. The block takes one transaction at a time.
// Reset: rst_n is synchronous, active low. After reset the cursor is 0 and a clearing pass
// writes a space to every cell while in_stall is high.
// Stall: a finished result sits in the output register until taken; while out_stall holds,
// the next result waits in the sequencer and in_stall stays high.
module text_console_cursor_and_scroll
  import tccs_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_COPY  = 6'b001000,
    S_FILL  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   cursor_r, cursor_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic            inrange_r, inrange_nxt;
  out_item_t       res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;

  logic            in_accept;
  logic            out_load;
  logic [AW:0]     cur_wide;
  logic [AW:0]     next_wide;
  logic [AW:0]     final_wide;
  logic            do_scroll;
  logic            is_bs;
  logic            is_nl;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_bs    = (in_data.char_code == CODE_BACKSPACE);
  assign is_nl    = (in_data.char_code == CODE_NEWLINE);
  assign cur_wide = {1'b0, cursor_r};

  // Cursor after the character, before any scroll. The column register spares a divider.
  always_comb begin
    if (is_bs) begin
      next_wide = (cursor_r == '0) ? cur_wide : cur_wide - (AW+1)'(1);
    end else if (is_nl) begin
      next_wide = cur_wide + (AW+1)'(COLUMNS) - (AW+1)'(col_r);
    end else begin
      next_wide = cur_wide + (AW+1)'(1);
    end
  end

  assign do_scroll  = (next_wide >= (AW+1)'(CELLS));
  assign final_wide = do_scroll ? next_wide - (AW+1)'(COLUMNS) : next_wide;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cursor_nxt  = cursor_r;
    col_nxt     = col_r;
    inrange_nxt = inrange_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = CODE_SPACE;
    ram_raddr   = AW'(in_data.cell_address);

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == AW'(CELLS - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_data.cmd == CMD_READ) begin
            inrange_nxt = (32'(in_data.cell_address) < 32'(CELLS));
            state_nxt   = S_READ;
          end else begin
            if (is_bs) begin
              if (cursor_r != '0) begin
                ram_we    = 1'b1;
                ram_waddr = cursor_r - AW'(1);
                col_nxt   = (col_r == '0) ? CW'(COLUMNS - 1) : col_r - CW'(1);
              end
            end else if (is_nl) begin
              col_nxt = '0;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cursor_r;
              ram_wdata = in_data.char_code;
              col_nxt   = (col_r == CW'(COLUMNS - 1)) ? '0 : col_r + CW'(1);
            end
            cursor_nxt           = AW'(final_wide);
            res_nxt.read_char    = '0;
            res_nxt.cursor_pos   = 12'(final_wide);
            res_nxt.scrolled     = do_scroll;
            res_nxt.request_done = in_data.last_char;
            idx_nxt              = '0;
            state_nxt            = do_scroll ? S_COPY : S_OUT;
          end
        end
      end
      S_READ: begin
        res_nxt.read_char    = inrange_r ? ram_rdata : '0;
        res_nxt.cursor_pos   = 12'(cursor_r);
        res_nxt.scrolled     = 1'b0;
        res_nxt.request_done = 1'b0;
        state_nxt            = S_OUT;
      end
      S_COPY: begin
        // Read one row ahead; the registered data returns in the next cycle and lands one cell behind.
        ram_raddr = AW'({1'b0, idx_r} + (AW+1)'(COLUMNS));
        ram_we    = (idx_r != '0);
        ram_waddr = idx_r - AW'(1);
        ram_wdata = ram_rdata;
        if (idx_r == AW'(CELLS - COLUMNS)) begin
          state_nxt = S_FILL;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_FILL: begin
        ram_we = 1'b1;
        if (idx_r == AW'(CELLS - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_data_nxt  = res_r;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      cursor_r    <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inrange_r  <= inrange_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  tccs_ram #(
    .WIDTH(8),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ({1'b0, cursor_r} < (AW+1)'(CELLS)))
    else $error("cursor left the screen");

  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.cmd == CMD_READ) |=> (state_r == S_READ))
    else $error("read transaction did not enter the read cycle");

  a_fill_bottom_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (idx_r >= AW'(CELLS - COLUMNS)))
    else $error("blanking outside the bottom row");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result appeared without a finished transaction");

endmodule

// File: design/tccs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: tb/sv/text_console_cursor_and_scroll_check.sv
// Checker for the text console: mirrors the screen and cursor and compares every result.
module text_console_cursor_and_scroll_check
  import tccs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        awaited_count
);

  localparam int CELL_COUNT = COLUMNS_DEF * ROWS_DEF;

  logic [7:0] screen_copy [CELL_COUNT];
  int         cursor_copy;
  out_item_t  console_results_q [$];

  // Applies one transaction to the mirrored console and returns the result it must produce.
  function automatic out_item_t apply_console_item(input in_item_t item);
    out_item_t res;
    int        idx;
    res = '0;
    if (item.cmd == CMD_READ) begin
      if (int'(item.cell_address) < CELL_COUNT) begin
        res.read_char = screen_copy[item.cell_address];
      end
    end else begin
      if (cursor_copy >= CELL_COUNT) cursor_copy = 0;
      case (item.char_code)
        CODE_BACKSPACE: begin
          if (cursor_copy > 0) begin
            cursor_copy--;
            screen_copy[cursor_copy] = CODE_SPACE;
          end
        end
        CODE_NEWLINE: begin
          cursor_copy = (cursor_copy / COLUMNS_DEF + 1) * COLUMNS_DEF;
        end
        default: begin
          screen_copy[cursor_copy] = item.char_code;
          cursor_copy++;
        end
      endcase
      // Past the bottom row: every row moves up and a blank row comes in at the bottom.
      if (cursor_copy / COLUMNS_DEF >= ROWS_DEF) begin
        for (idx = 0; idx < CELL_COUNT - COLUMNS_DEF; idx++) begin
          screen_copy[idx] = screen_copy[idx + COLUMNS_DEF];
        end
        for (idx = CELL_COUNT - COLUMNS_DEF; idx < CELL_COUNT; idx++) begin
          screen_copy[idx] = CODE_SPACE;
        end
        cursor_copy -= COLUMNS_DEF;
        res.scrolled = 1'b1;
      end
      res.request_done = item.last_char;
    end
    res.cursor_pos = cursor_copy[11:0];
    return res;
  endfunction

  function automatic int field_differs(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    int        bad;
    if (!rst_n) begin
      for (int idx = 0; idx < CELL_COUNT; idx++) screen_copy[idx] = CODE_SPACE;
      cursor_copy = 0;
      console_results_q.delete();
      fail_count    <= 0;
      awaited_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (console_results_q.size() == 0) begin
          $display("%0t: result with no transaction awaiting it: actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = console_results_q[0];
          console_results_q.delete(0);
          bad = field_differs("read_char", int'(want.read_char), int'(out_data.read_char))
              + field_differs("cursor_pos", int'(want.cursor_pos), int'(out_data.cursor_pos))
              + field_differs("scrolled", int'(want.scrolled), int'(out_data.scrolled))
              + field_differs("request_done", int'(want.request_done),
                              int'(out_data.request_done));
          if (bad != 0) fail_count <= fail_count + 1;
        end
      end
      if (in_valid && !in_stall) begin
        console_results_q = {console_results_q, apply_console_item(in_data)};
      end
      awaited_count <= console_results_q.size();
    end
  end

endmodule

// File: tb/sv/text_console_cursor_and_scroll_test.sv
// Testbench top for the text console: reset, stimulus, output stalls and the verdict.
module text_console_cursor_and_scroll_test
  import tccs_pkg::*;
();

  localparam int CELL_COUNT     = COLUMNS_DEF * ROWS_DEF;
  localparam int ITEM_TARGET    = 1000;
  localparam int TIMEOUT_CYCLES = 12_000_000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        awaited_count;

  int        items_sent;
  int        burst_left;
  int        stall_mode;
  int        stall_mode_left;
  int        stall_phase;

  text_console_cursor_and_scroll i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  text_console_cursor_and_scroll_check i_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .awaited_count(awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("status: fail");
    $finish;
  end

  // The receiver switches between no stalls, light, heavy and alternating stalls.
  initial begin
    out_stall       = 1'b0;
    stall_mode      = 0;
    stall_mode_left = 0;
    stall_phase     = 0;
  end

  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(10, 200);
    end
    stall_mode_left--;
    stall_phase++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 4) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_phase[0];
    endcase
  end

  function automatic in_item_t write_item(input logic [7:0] code, input logic last);
    in_item_t item;
    item.cmd          = CMD_WRITE;
    item.char_code    = code;
    item.cell_address = 12'($urandom());
    item.last_char    = last;
    return item;
  endfunction

  function automatic in_item_t read_item(input logic [11:0] addr);
    in_item_t item;
    item.cmd          = CMD_READ;
    item.char_code    = 8'($urandom());
    item.cell_address = addr;
    item.last_char    = 1'($urandom());
    return item;
  endfunction

  function automatic logic [7:0] random_code();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return CODE_NEWLINE;
    if (pick < 13) return CODE_BACKSPACE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [11:0] random_address();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 12'($urandom_range(0, CELL_COUNT - 1));
    if (pick < 70) return 12'($urandom_range(CELL_COUNT - 2 * COLUMNS_DEF, CELL_COUNT - 1));
    if (pick < 85) return 12'($urandom_range(CELL_COUNT, 4095));
    return 12'($urandom());
  endfunction

  // Sends one transaction; the sender works in bursts with random gaps between them.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  // Holds the sender off until every transaction has returned its result.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_count != 0) @(posedge clk);
  endtask

  task automatic send_write_request();
    int count;
    count = $urandom_range(1, 20);
    for (int idx = 0; idx < count; idx++) begin
      send_item(write_item(random_code(), idx == count - 1));
    end
  endtask

  initial begin
    int pick;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    items_sent = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Blank screen after reset, reads beyond the screen, backspace at cell zero.
    send_item(read_item(12'd0));
    send_item(read_item(12'(CELL_COUNT - 1)));
    send_item(read_item(12'(CELL_COUNT)));
    send_item(read_item(12'hFFF));
    send_item(write_item(CODE_BACKSPACE, 1'b1));
    send_item(write_item(8'h00, 1'b0));
    send_item(write_item(8'hFF, 1'b0));
    send_item(write_item(8'h41, 1'b1));
    send_item(read_item(12'd0));
    send_item(read_item(12'd1));
    send_item(read_item(12'd2));
    send_item(write_item(CODE_BACKSPACE, 1'b0));
    send_item(read_item(12'd2));
    send_item(write_item(CODE_NEWLINE, 1'b1));
    send_item(write_item(8'h7F, 1'b1));
    send_item(read_item(12'(COLUMNS_DEF)));
    send_item(read_item(12'h800));
    drain_results();

    // Newlines down to the bottom row and two more, then a character run that wraps
    // past the last cell, so both kinds of write make the screen scroll.
    for (int idx = 0; idx < ROWS_DEF; idx++) begin
      send_item(write_item(CODE_NEWLINE, idx == ROWS_DEF - 1));
    end
    for (int idx = 0; idx < COLUMNS_DEF + 6; idx++) begin
      send_item(write_item(8'($urandom_range(33, 126)), idx == COLUMNS_DEF + 5));
    end
    for (int idx = 0; idx < 4; idx++) begin
      send_item(read_item(12'(CELL_COUNT - 2 * COLUMNS_DEF
                              + $urandom_range(0, 2 * COLUMNS_DEF - 1))));
    end
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_write_request();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) send_item(read_item(random_address()));
      end else if (pick < 98) begin
        send_item(($urandom_range(0, 1) == 0) ? read_item(12'($urandom()))
                                              : write_item(8'($urandom()), 1'($urandom())));
      end else begin
        drain_results();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
